FILE: hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants of the scene text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int OFFSET_BITS_DEF = 20;
  localparam int START_W         = 20;
  localparam int LEN_W           = 21;
  localparam int KIND_W          = 2;
  localparam int OUT_DATA_W      = 48;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_QUOTE   = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BRACKET = 2'd0,
    KIND_QUOTED  = 2'd1,
    KIND_WORD    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    kind_t              kind;
  } tok_t;

  // first token always present, second is a one-byte bracket or quote
  typedef struct packed {
    tok_t               a;
    logic               b_vld;
    logic [START_W-1:0] b_start;
    kind_t              b_kind;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    cmd_t head;
  } q_stat_t;

endpackage

FILE: hw/rtl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// scans one byte per beat, tracks the token mode and forms token commands
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    text_byte,
  input  logic          final_byte,
  input  logic          q_full,
  output logic          push,
  output stt_pkg::cmd_t cmd
);

  stt_pkg::mode_t         mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] ps_r, ps_nxt;

  logic                   accept;
  logic                   is_space, is_brack, is_quote, is_hash, is_eol, is_delim;
  logic [OFFSET_BITS-1:0] diff;
  logic [OFFSET_BITS:0]   len_incl, len_prev;
  logic [OFFSET_BITS-1:0] a_start;
  logic [OFFSET_BITS:0]   a_len;
  logic [31:0]            a_start_ext, p_ext;
  logic [32:0]            a_len_ext;
  logic                   tok_vld;
  stt_pkg::kind_t         a_kind;
  logic                   b_vld;
  stt_pkg::kind_t         b_kind;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign is_space = text_byte inside {stt_pkg::CH_SPACE, stt_pkg::CH_TAB,
                                      stt_pkg::CH_CR, stt_pkg::CH_LF};
  assign is_eol   = text_byte inside {stt_pkg::CH_CR, stt_pkg::CH_LF};
  assign is_brack = text_byte inside {stt_pkg::CH_LBRACK, stt_pkg::CH_RBRACK};
  assign is_quote = (text_byte == stt_pkg::CH_QUOTE);
  assign is_hash  = (text_byte == stt_pkg::CH_HASH);
  assign is_delim = is_space || is_brack || is_quote;

  // lengths wrap with the offsets; a word spanning the whole range gets full length
  assign diff     = pos_r - ps_r;
  assign len_incl = {1'b0, diff} + (OFFSET_BITS+1)'(1);
  assign len_prev = (diff == '0) ? {1'b1, {OFFSET_BITS{1'b0}}} : {1'b0, diff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stt_pkg::MODE_IDLE;
      pos_r  <= '0;
      ps_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ps_r   <= ps_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    ps_nxt   = ps_r;
    tok_vld  = 1'b0;
    a_start  = ps_r;
    a_len    = len_incl;
    a_kind   = stt_pkg::KIND_WORD;
    b_vld    = 1'b0;
    b_kind   = stt_pkg::KIND_BRACKET;
    case (mode_r)
      stt_pkg::MODE_WORD: begin
        if (is_delim) begin
          tok_vld  = 1'b1;
          a_len    = len_prev;
          mode_nxt = stt_pkg::MODE_IDLE;
          // the delimiter is then handled as a fresh byte
          if (is_brack) begin
            b_vld = 1'b1;
          end else if (is_quote) begin
            mode_nxt = stt_pkg::MODE_QUOTE;
            ps_nxt   = pos_r;
            if (final_byte) begin
              b_vld  = 1'b1;
              b_kind = stt_pkg::KIND_QUOTED;
            end
          end
        end else if (final_byte) begin
          tok_vld = 1'b1;
        end
      end
      stt_pkg::MODE_QUOTE: begin
        if (is_quote || final_byte) begin
          tok_vld  = 1'b1;
          a_kind   = stt_pkg::KIND_QUOTED;
          mode_nxt = stt_pkg::MODE_IDLE;
        end
      end
      stt_pkg::MODE_COMMENT: begin
        if (is_eol) begin
          mode_nxt = stt_pkg::MODE_IDLE;
        end
      end
      default: begin
        a_start = pos_r;
        a_len   = (OFFSET_BITS+1)'(1);
        if (is_brack) begin
          tok_vld = 1'b1;
          a_kind  = stt_pkg::KIND_BRACKET;
        end else if (is_space) begin
          mode_nxt = stt_pkg::MODE_IDLE;
        end else if (is_quote) begin
          mode_nxt = stt_pkg::MODE_QUOTE;
          ps_nxt   = pos_r;
          tok_vld  = final_byte;
          a_kind   = stt_pkg::KIND_QUOTED;
        end else if (is_hash) begin
          mode_nxt = stt_pkg::MODE_COMMENT;
        end else begin
          mode_nxt = stt_pkg::MODE_WORD;
          ps_nxt   = pos_r;
          tok_vld  = final_byte;
        end
      end
    endcase
    if (final_byte) begin
      mode_nxt = stt_pkg::MODE_IDLE;
      pos_nxt  = '0;
    end else begin
      pos_nxt  = pos_r + OFFSET_BITS'(1);
    end
  end

  assign a_start_ext = 32'(a_start);
  assign a_len_ext   = 33'(a_len);
  assign p_ext       = 32'(pos_r);

  assign cmd  = {a_start_ext[stt_pkg::START_W-1:0], a_len_ext[stt_pkg::LEN_W-1:0], a_kind,
                 b_vld, p_ext[stt_pkg::START_W-1:0], b_kind};
  assign push = accept && tok_vld;

`ifndef SYNTHESIS
  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && final_byte) |=> (pos_r == '0 && mode_r == stt_pkg::MODE_IDLE))
    else $error("text end did not restart the scan");
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd.b_vld) |-> (push && mode_r == stt_pkg::MODE_WORD))
    else $error("second token outside a word close");
`endif

endmodule

FILE: hw/rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// short command queue between the scanner and the token emitter
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stt_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output stt_pkg::q_stat_t stat
);

  localparam int DEPTH = stt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stt_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.head  = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("command pushed into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

FILE: hw/rtl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// emits one or two token beats for each queued command
// ----------------------------------------------------------------------------
module stt_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stt_pkg::q_stat_t               stat,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [stt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [stt_pkg::KIND_W-1:0]     out_tuser,
  output logic                           out_tlast
);

  localparam int PAD_W = stt_pkg::OUT_DATA_W - stt_pkg::START_W - stt_pkg::LEN_W;

  logic               phase_r, phase_nxt;
  logic               beat;
  logic [stt_pkg::START_W-1:0] start;
  logic [stt_pkg::LEN_W-1:0]   len;
  stt_pkg::kind_t     kind;

  assign out_tvalid = !stat.empty;
  assign beat       = out_tvalid && out_tready;

  always_comb begin
    if (phase_r) begin
      start = stat.head.b_start;
      len   = stt_pkg::LEN_W'(1);
      kind  = stat.head.b_kind;
    end else begin
      start = stat.head.a.start;
      len   = stat.head.a.len;
      kind  = stat.head.a.kind;
    end
  end

  assign out_tlast = phase_r || !stat.head.b_vld;
  assign out_tdata = {{PAD_W{1'b0}}, len, start};
  assign out_tuser = kind;
  assign pop       = beat && out_tlast;

  always_comb begin
    phase_nxt = phase_r;
    if (beat) begin
      phase_nxt = !out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

`ifndef SYNTHESIS
  a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !out_tlast) |=> (out_tvalid && phase_r && out_tlast))
    else $error("second token beat missing");
`endif

endmodule

FILE: hw/rtl/scene_text_tokenizer_core.sv
// a token command is queued when the byte that closes it is accepted; its beat is offered from the queue head
// throughput: one text byte per cycle while the command queue is not full; a byte that closes a word
//   and also yields a bracket, or a quote that is the final byte, emits two token beats, the command queue absorbs it
// rate is set by the registered mode switch in the scanner and one beat per cycle out while out_tready is high
// reset: synchronous, clears scan mode, byte offset and the command queue
// ----------------------------------------------------------------------------
// scene_text_tokenizer_core
// splits a byte stream into bracket, quoted string and bare word tokens
// ----------------------------------------------------------------------------
module scene_text_tokenizer_core #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // text_byte
  input  logic                           in_tlast,   // final_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [stt_pkg::OUT_DATA_W-1:0] out_tdata,  // token_start, token_length
  output logic [stt_pkg::KIND_W-1:0]     out_tuser,  // token_kind
  output logic                           out_tlast   // last_of_run
);

  logic             push, pop;
  stt_pkg::cmd_t    cmd;
  stt_pkg::q_stat_t stat;

  stt_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .text_byte  (in_tdata),
    .final_byte (in_tlast),
    .q_full     (stat.full),
    .push       (push),
    .cmd        (cmd)
  );

  stt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .stat     (stat)
  );

  stt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
